@@ hw/rtl/bsle_pkg.sv @@
// ----------------------------------------------------------------------------
// bsle_pkg: shared definitions for the bounded sequence list engine
// Holds the list capacity, the field widths, the operation codes and the
// sequencer state type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bsle_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VAL_W    = 32;
    localparam int POS_W    = 8;

    typedef logic signed [VAL_W-1:0] value_t;
    typedef logic [POS_W-1:0]        pos_t;
    typedef logic [IDX_W-1:0]        idx_t;
    typedef logic [CNT_W-1:0]        cnt_t;

    typedef enum logic [1:0] {
        OP_PUSH_FRONT = 2'd0,
        OP_PUSH_BACK  = 2'd1,
        OP_DELETE     = 2'd2,
        OP_NOP        = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_PUT,
        ST_DUMP
    } state_t;

endpackage

`default_nettype wire

@@ hw/rtl/bounded_sequence_list_engine.sv @@
// ----------------------------------------------------------------------------
// bounded_sequence_list_engine: ordered list of signed 32-bit values
// Applies one operation per input transaction and then streams the whole
// list, front to back, on the result channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

// The block keeps up to CAPACITY signed values in a single-port-write,
// single-port-read memory and takes one input transaction at a time; s_ready
// is high only while the sequencer is idle. An insert at the front moves every
// stored entry up by one place, and a delete moves every entry above the
// removed one down by one place; each move is a read step followed by a
// write step through the one memory port pair, and the list is streamed
// once the moves are done. An append or an ignored operation needs no moves.
// The list is streamed at one result transaction per cycle while m_ready is
// high, N results, where N is the entry count (or a single result flagged
// empty). The result register decouples the two sides: the next input
// transaction is accepted while the last result of the previous item still
// waits. The memory needs no clearing after reset; only entries below the
// count, as it stands before or after the operation, are ever read.

module bounded_sequence_list_engine (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire bsle_pkg::op_t  s_op,
    input  wire bsle_pkg::value_t s_value,
    input  wire bsle_pkg::pos_t s_position,
    output logic                m_valid,
    input  wire logic           m_ready,
    output bsle_pkg::value_t    m_element,
    output logic                m_is_last,
    output logic                m_list_empty,
    output logic                m_dropped
);

    import bsle_pkg::*;

    // Sequencer and list bookkeeping.
    state_t state_reg, state_next;
    op_t    op_reg, op_next;
    value_t value_reg, value_next;
    idx_t   put_addr_reg, put_addr_next;
    cnt_t   idx_reg, idx_next;
    cnt_t   count_reg, count_next;
    logic   drop_reg, drop_next;

    // Dump pipeline: issue index, load index and a flag that says the
    // memory read register holds an element not yet moved to the output.
    cnt_t   iss_reg, iss_next;
    cnt_t   ld_reg, ld_next;
    logic   pend_reg, pend_next;

    // Result register.
    logic   m_valid_reg, m_valid_next;
    value_t m_element_reg, m_element_next;
    logic   m_is_last_reg, m_is_last_next;
    logic   m_list_empty_reg, m_list_empty_next;
    logic   m_dropped_reg, m_dropped_next;

    // List storage.
    value_t mem [CAPACITY];
    logic   wr_en;
    idx_t   wr_addr;
    value_t wr_data;
    logic   rd_en;
    idx_t   rd_addr;
    value_t rd_data_reg;

    logic   out_free;
    logic   load;
    logic   issue;
    logic   full;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg           <= op_next;
        value_reg        <= value_next;
        put_addr_reg     <= put_addr_next;
        idx_reg          <= idx_next;
        drop_reg         <= drop_next;
        iss_reg          <= iss_next;
        ld_reg           <= ld_next;
        m_element_reg    <= m_element_next;
        m_is_last_reg    <= m_is_last_next;
        m_list_empty_reg <= m_list_empty_next;
        m_dropped_reg    <= m_dropped_next;
    end

    assign full     = (count_reg == cnt_t'(CAPACITY));
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next        = state_reg;
        op_next           = op_reg;
        value_next        = value_reg;
        put_addr_next     = put_addr_reg;
        idx_next          = idx_reg;
        count_next        = count_reg;
        drop_next         = drop_reg;
        iss_next          = iss_reg;
        ld_next           = ld_reg;
        pend_next         = pend_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        m_element_next    = m_element_reg;
        m_is_last_next    = m_is_last_reg;
        m_list_empty_next = m_list_empty_reg;
        m_dropped_next    = m_dropped_reg;
        wr_en             = 1'b0;
        wr_addr           = put_addr_reg;
        wr_data           = value_reg;
        rd_en             = 1'b0;
        rd_addr           = iss_reg[IDX_W-1:0];
        load              = 1'b0;
        issue             = 1'b0;
        s_ready           = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    op_next    = s_op;
                    value_next = s_value;
                    drop_next  = 1'b0;
                    iss_next   = '0;
                    ld_next    = '0;
                    state_next = ST_DUMP;
                    unique case (s_op)
                        OP_PUSH_FRONT: begin
                            if (full) begin
                                drop_next = 1'b1;
                            end else begin
                                put_addr_next = '0;
                                idx_next      = count_reg;
                                state_next    = (count_reg == '0) ? ST_PUT : ST_SHIFT_RD;
                            end
                        end
                        OP_PUSH_BACK: begin
                            if (full) begin
                                drop_next = 1'b1;
                            end else begin
                                put_addr_next = count_reg[IDX_W-1:0];
                                state_next    = ST_PUT;
                            end
                        end
                        OP_DELETE: begin
                            if (s_position < POS_W'(count_reg)) begin
                                // The count drops now; the moves run while
                                // the index stays below the new count.
                                count_next = count_reg - cnt_t'(1);
                                idx_next   = s_position[CNT_W-1:0];
                                if (s_position[CNT_W-1:0] + cnt_t'(1) < count_reg) begin
                                    state_next = ST_SHIFT_RD;
                                end
                            end
                        end
                        OP_NOP: begin
                        end
                        default: begin
                        end
                    endcase
                end
            end

            ST_SHIFT_RD: begin
                rd_en = 1'b1;
                if (op_reg == OP_PUSH_FRONT) begin
                    rd_addr = idx_t'(idx_reg - cnt_t'(1));
                end else begin
                    rd_addr = idx_t'(idx_reg + cnt_t'(1));
                end
                state_next = ST_SHIFT_WR;
            end

            ST_SHIFT_WR: begin
                wr_en   = 1'b1;
                wr_addr = idx_reg[IDX_W-1:0];
                wr_data = rd_data_reg;
                if (op_reg == OP_PUSH_FRONT) begin
                    idx_next   = idx_reg - cnt_t'(1);
                    state_next = (idx_reg == cnt_t'(1)) ? ST_PUT : ST_SHIFT_RD;
                end else begin
                    idx_next   = idx_reg + cnt_t'(1);
                    state_next = (idx_reg + cnt_t'(2) < count_reg + cnt_t'(1))
                                 ? ST_SHIFT_RD : ST_DUMP;
                end
            end

            ST_PUT: begin
                wr_en      = 1'b1;
                count_next = count_reg + cnt_t'(1);
                state_next = ST_DUMP;
            end

            ST_DUMP: begin
                if (count_reg == '0) begin
                    // An empty list still reports one result.
                    if (out_free) begin
                        m_valid_next      = 1'b1;
                        m_element_next    = '0;
                        m_is_last_next    = 1'b1;
                        m_list_empty_next = 1'b1;
                        m_dropped_next    = drop_reg;
                        state_next        = ST_IDLE;
                    end
                end else begin
                    load  = pend_reg && out_free;
                    issue = (iss_reg < count_reg) && (!pend_reg || load);
                    if (issue) begin
                        rd_en    = 1'b1;
                        iss_next = iss_reg + cnt_t'(1);
                    end
                    pend_next = issue || (pend_reg && !load);
                    if (load) begin
                        m_valid_next      = 1'b1;
                        m_element_next    = rd_data_reg;
                        m_is_last_next    = (ld_reg == count_reg - cnt_t'(1));
                        m_list_empty_next = 1'b0;
                        m_dropped_next    = drop_reg;
                        ld_next           = ld_reg + cnt_t'(1);
                        if (ld_reg == count_reg - cnt_t'(1)) begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid      = m_valid_reg;
    assign m_element    = m_element_reg;
    assign m_is_last    = m_is_last_reg;
    assign m_list_empty = m_list_empty_reg;
    assign m_dropped    = m_dropped_reg;

endmodule

`default_nettype wire

@@ hw/rtl/bsle_checker.sv @@
// ----------------------------------------------------------------------------
// bsle_checker: port-level checks for the bounded sequence list engine
// Watches the top-level ports over time and is bound to every instance.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bsle_checker (
    input wire logic             aclk,
    input wire logic             aresetn,
    input wire logic             s_valid,
    input wire logic             s_ready,
    input wire bsle_pkg::op_t    s_op,
    input wire bsle_pkg::value_t s_value,
    input wire bsle_pkg::pos_t   s_position,
    input wire logic             m_valid,
    input wire logic             m_ready,
    input wire bsle_pkg::value_t m_element,
    input wire logic             m_is_last,
    input wire logic             m_list_empty,
    input wire logic             m_dropped
);

    // A stalled result transaction holds its element and its last flag.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_element) && $stable(m_is_last))
        else $error("result transaction changed while stalled");

    // An empty-list result is the only result of its item and carries zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_list_empty |-> m_is_last && (m_element == '0))
        else $error("empty-list result malformed");

    // An insert can only be refused when the list is full, never when empty.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_list_empty |-> !m_dropped)
        else $error("dropped flag on an empty list");

    // Accepting an item takes the sequencer out of idle, which drops s_ready.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted on consecutive cycles");

endmodule

bind bounded_sequence_list_engine bsle_checker u_bsle_checker (.*);

`default_nettype wire

@@ test/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the bounded sequence list engine
// Drives list operations (front insert, back append, positional delete and
// no-change) with random idle gaps on both channels, keeps a shadow copy of
// the list, and checks every streamed list entry field by field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    import bsle_pkg::*;

    // Run limits. The slowest correct item is a front insert into a nearly
    // full list, which shifts every entry, followed by 16 results that each
    // wait out the longest sink stall, plus the longest sender gap. About 230
    // items fit well within the limit below, which leaves a wide margin.
    localparam int unsigned LIMIT_CYCLES = 600000;
    localparam int unsigned TAIL_CYCLES  = 64;
    localparam int unsigned RANDOM_ITEMS = 200;
    localparam int unsigned PRINT_CAP    = 50;

    // One input transaction, with the idle time the sender spends before it
    // and a flag that holds it back until the result channel has drained.
    typedef struct {
        op_t         op;
        value_t      value;
        pos_t        position;
        int unsigned gap;
        bit          drain;
    } list_op_t;

    // One expected list entry on the result channel.
    typedef struct {
        value_t element;
        logic   is_last;
        logic   list_empty;
        logic   dropped;
    } dump_entry_t;

    logic   aclk         = 1'b0;
    logic   aresetn      = 1'b0;
    logic   s_valid      = 1'b0;
    logic   s_ready;
    op_t    s_op         = OP_NOP;
    value_t s_value      = '0;
    pos_t   s_position   = '0;
    logic   m_valid;
    logic   m_ready      = 1'b0;
    value_t m_element;
    logic   m_is_last;
    logic   m_list_empty;
    logic   m_dropped;

    list_op_t    pending_q[$];   // operations not yet offered to the block
    dump_entry_t dump_q[$];      // list entries the block still owes us
    value_t      shadow_list[$]; // our own copy of the list, front first

    int unsigned mismatches = 0;
    int unsigned cycles     = 0;
    int unsigned gen_count  = 0; // list length as seen while building stimulus
    bit          tx_calm    = 1'b0;
    bit          rx_calm    = 1'b0;

    bounded_sequence_list_engine DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_op         (s_op),
        .s_value      (s_value),
        .s_position   (s_position),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_element    (m_element),
        .m_is_last    (m_is_last),
        .m_list_empty (m_list_empty),
        .m_dropped    (m_dropped)
    );

    // 4 ns clock: low half, then high half.
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Every failure goes through here. Printing stops after a while so a badly
    // broken block cannot flood the log, but the count keeps going.
    task automatic report_diff(input string what);
        mismatches++;
        if (mismatches <= PRINT_CAP) begin
            $display("[%0t] check failed: %s", $time, what);
        end
    endtask

    // Idle time for one item or one result. Calm stretches use no idling at
    // all; otherwise short gaps are as likely as long ones, so stalls land on
    // every phase of the shift and dump sequences.
    function automatic int unsigned pick_wait(input bit calm);
        if (calm) begin
            return 0;
        end
        return $urandom_range(0, ($urandom_range(0, 1) != 0) ? 3 : 19);
    endfunction

    // Values lean toward the corners of the signed range now and then.
    function automatic value_t pick_value();
        case ($urandom_range(0, 11))
            0:       return value_t'(32'h8000_0000);
            1:       return value_t'(32'h7FFF_FFFF);
            2:       return '0;
            3:       return '1;
            default: return value_t'($urandom);
        endcase
    endfunction

    // Queues one operation for the driver and tracks the list length so that
    // later deletes can aim at positions that actually exist.
    task automatic queue_op(input op_t op, input value_t value, input pos_t position,
                            input bit drain);
        list_op_t item;
        if ($urandom_range(0, 9) == 0) begin
            tx_calm = !tx_calm;
        end
        item.op       = op;
        item.value    = value;
        item.position = position;
        item.gap      = pick_wait(tx_calm);
        item.drain    = drain;
        pending_q.push_back(item);
        case (op)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
                if (gen_count < CAPACITY) begin
                    gen_count++;
                end
            end
            OP_DELETE: begin
                if (int'(position) < gen_count) begin
                    gen_count--;
                end
            end
            default: ;
        endcase
    endtask

    // Applies one accepted operation to the shadow list, then records the whole
    // list as the results it must produce. A refused insert leaves the list as
    // it was and flags every result of the item; an empty list yields a single
    // entry marked empty with a zero element.
    function automatic void apply_and_dump(input op_t op, input value_t value,
                                           input pos_t position);
        bit          refused;
        dump_entry_t entry;
        refused = 1'b0;
        case (op)
            OP_PUSH_FRONT: begin
                if (shadow_list.size() < CAPACITY) begin
                    shadow_list.push_front(value);
                end else begin
                    refused = 1'b1;
                end
            end
            OP_PUSH_BACK: begin
                if (shadow_list.size() < CAPACITY) begin
                    shadow_list.push_back(value);
                end else begin
                    refused = 1'b1;
                end
            end
            OP_DELETE: begin
                // A position past the end is simply ignored.
                if (int'(position) < shadow_list.size()) begin
                    shadow_list.delete(int'(position));
                end
            end
            default: ;
        endcase
        if (shadow_list.size() == 0) begin
            entry = '{element: '0, is_last: 1'b1, list_empty: 1'b1, dropped: refused};
            dump_q.push_back(entry);
        end else begin
            foreach (shadow_list[k]) begin
                entry.element    = shadow_list[k];
                entry.is_last    = (k == shadow_list.size() - 1);
                entry.list_empty = 1'b0;
                entry.dropped    = refused;
                dump_q.push_back(entry);
            end
        end
    endfunction

    // Driver. An operation goes out after its idle gap; once valid is up it
    // stays up, payload frozen, until the block takes it. With a zero gap the
    // next transaction is driven in the cycle right after the previous one is accepted.
    // Items flagged for draining wait until every owed result has arrived.
    int unsigned gap_left  = 0;
    bit          gap_armed = 1'b0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid   <= 1'b0;
            gap_armed = 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                apply_and_dump(s_op, s_value, s_position);
            end
            if (s_valid && !s_ready) begin
                // Still waiting for the block; hold everything.
            end else if (pending_q.size() == 0) begin
                s_valid <= 1'b0;
            end else begin
                if (!gap_armed) begin
                    gap_left  = pending_q[0].gap;
                    gap_armed = 1'b1;
                end
                if (gap_left != 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (pending_q[0].drain && dump_q.size() != 0) begin
                    s_valid <= 1'b0;
                end else begin
                    s_valid    <= 1'b1;
                    s_op       <= pending_q[0].op;
                    s_value    <= pending_q[0].value;
                    s_position <= pending_q[0].position;
                    void'(pending_q.pop_front());
                    gap_armed = 1'b0;
                end
            end
        end
    end

    // Monitor. Each accepted result is matched against the oldest owed list
    // entry. After every transaction the sink draws a stall and holds ready low
    // while the stall counts down, with calm stretches where ready stays high throughout.
    int unsigned stall_left = 0;

    always @(posedge aclk) begin
        dump_entry_t want;
        if (!aresetn) begin
            m_ready    <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (dump_q.size() == 0) begin
                    report_diff($sformatf("unexpected result, element %0d", m_element));
                end else begin
                    want = dump_q.pop_front();
                    if (m_element !== want.element) begin
                        report_diff($sformatf("element %0d, want %0d",
                                              m_element, want.element));
                    end
                    if (m_is_last !== want.is_last) begin
                        report_diff($sformatf("is_last %b, want %b",
                                              m_is_last, want.is_last));
                    end
                    if (m_list_empty !== want.list_empty) begin
                        report_diff($sformatf("list_empty %b, want %b",
                                              m_list_empty, want.list_empty));
                    end
                    if (m_dropped !== want.dropped) begin
                        report_diff($sformatf("dropped %b, want %b",
                                              m_dropped, want.dropped));
                    end
                end
                if ($urandom_range(0, 24) == 0) begin
                    rx_calm = !rx_calm;
                end
                stall_left = pick_wait(rx_calm);
            end else if (stall_left != 0) begin
                stall_left--;
            end
            m_ready <= (stall_left == 0);
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge aclk) begin
        cycles++;
        if (cycles >= LIMIT_CYCLES) begin
            $display("bounded_sequence_list_engine: mismatch");
            $finish;
        end
    end

    initial begin
        bit growing;
        op_t pick;
        pos_t where;
        int unsigned roll;

        // Directed part. It starts on the empty list, covers the value corners,
        // deletes past the end and in the middle, fills the list to capacity,
        // tries both inserts on the full list, then trims both ends.
        queue_op(OP_DELETE, '0, 8'd0, 1'b0);                          // delete on empty
        queue_op(OP_NOP, '1, 8'hFF, 1'b0);                            // no change, empty
        queue_op(OP_PUSH_FRONT, value_t'(32'h8000_0000), 8'hFF, 1'b0);
        queue_op(OP_PUSH_BACK, value_t'(32'h7FFF_FFFF), 8'hAA, 1'b0);
        queue_op(OP_PUSH_FRONT, '1, 8'h00, 1'b0);
        queue_op(OP_PUSH_BACK, '0, 8'h55, 1'b0);
        queue_op(OP_DELETE, value_t'($urandom), 8'hFF, 1'b0);          // far past the end
        queue_op(OP_DELETE, value_t'($urandom), 8'd4, 1'b0);           // exactly at the end
        queue_op(OP_DELETE, value_t'($urandom), 8'd1, 1'b0);           // from the middle
        queue_op(OP_NOP, value_t'($urandom), 8'd0, 1'b0);
        while (gen_count < CAPACITY) begin
            queue_op((gen_count % 2 != 0) ? OP_PUSH_BACK : OP_PUSH_FRONT,
                     pick_value(), pos_t'($urandom_range(0, 255)), 1'b0);
        end
        queue_op(OP_PUSH_FRONT, pick_value(), 8'd0, 1'b0);             // refused, full
        queue_op(OP_PUSH_BACK, pick_value(), 8'd0, 1'b0);              // refused, full
        queue_op(OP_DELETE, '0, pos_t'(CAPACITY - 1), 1'b1);           // last entry
        queue_op(OP_DELETE, '0, 8'd0, 1'b0);                           // first entry

        // Random part. The mix swings between growing and shrinking the list
        // so that it keeps running into both the full and the empty case.
        // Most deletes aim inside the list; the rest use any position.
        growing = 1'b0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            roll = $urandom_range(0, 99);
            if (growing) begin
                pick = (roll < 40) ? OP_PUSH_FRONT : (roll < 80) ? OP_PUSH_BACK :
                       (roll < 92) ? OP_DELETE : OP_NOP;
            end else begin
                pick = (roll < 72) ? OP_DELETE : (roll < 84) ? OP_PUSH_FRONT :
                       (roll < 93) ? OP_PUSH_BACK : OP_NOP;
            end
            if (pick == OP_DELETE && gen_count != 0 && $urandom_range(0, 9) != 0) begin
                where = pos_t'($urandom_range(0, gen_count - 1));
            end else begin
                where = pos_t'($urandom_range(0, 255));
            end
            queue_op(pick, pick_value(), where, (n % 50 == 0));
            if (gen_count == CAPACITY) begin
                growing = 1'b0;
            end else if (gen_count == 0) begin
                growing = 1'b1;
            end else if ($urandom_range(0, 29) == 0) begin
                growing = !growing;
            end
        end

        // Synchronous reset, applied once at the start and then released.
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Wait until every operation has gone in and every owed result has
        // come out, then give stray results a short window to show up.
        while (pending_q.size() != 0 || s_valid || dump_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (mismatches == 0) begin
            $display("bounded_sequence_list_engine: match");
        end else begin
            $display("bounded_sequence_list_engine: mismatch");
        end
        $finish;
    end

endmodule
